// ----- hw/rtl/tram_pkg.sv -----
// types and constants for the two-register alu machine
// no dependencies; imported by two_register_alu_machine
package tram_pkg;

  // request codes on req_type
  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_READ = 3'd1,
    OP_ADD  = 3'd2,
    OP_MUL  = 3'd3,
    OP_SUB  = 3'd4,
    OP_DIV  = 3'd5
  } op_t;

  // result kinds on result_kind
  localparam logic KIND_DATA     = 1'b0;
  localparam logic KIND_DIV_ZERO = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_ABS_N,
    S_DIV_ABS_D,
    S_DIV,
    S_DIV_FIX,
    S_WAIT_OUT
  } state_t;

endpackage

// ----- hw/rtl/two_register_alu_machine.sv -----
// two-register integer alu: registers a and b, one shared adder under a sequencer
// depends on tram_pkg
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  request | in_valid in_ready req_type dest_sel src_sel    | in
//          | immediate                                      |
//  result  | out_valid out_ready result_kind read_value     | out
//
// load, read, add, subtract and unused codes are handled in the idle state; multiply
// and divide run the one-bit-per-cycle shift-add and restoring-divide loops over
// the single shared adder.
// reset clears both registers to zero and empties the result register.
// a result waits in the output register while the next request is taken;
// a second result stalls the sequencer until the first one is taken.
module two_register_alu_machine #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic        dest_sel,
  input  logic        src_sel,
  input  logic signed [31:0] immediate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic signed [31:0] read_value
);
  import tram_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  state_t              state, state_next;
  logic [W-1:0]        reg_a, reg_a_next;
  logic [W-1:0]        reg_b, reg_b_next;
  logic [W:0]          acc, acc_next;
  logic [W-1:0]        opx, opx_next;
  logic [W-1:0]        opy, opy_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                dst_b, dst_b_next;
  logic                neg_n, neg_n_next;
  logic                neg_d, neg_d_next;
  logic                out_valid_next;
  logic                result_kind_next;
  logic signed [31:0]  read_value_next;
  logic                pend_kind, pend_kind_next;
  logic signed [31:0]  pend_value, pend_value_next;

  // shared adder
  logic [W:0]          add_a, add_b, add_sum;
  logic                add_cin;

  logic [W-1:0]        cur_dst, cur_src, imm_w, wr_val;
  logic signed [W-1:0] rd_reg;
  logic [W:0]          rem_sh;
  logic                accept, slot_free, cnt_last, wr_en, wr_sel;

  assign add_sum = add_a + add_b + {{W{1'b0}}, add_cin};

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign cnt_last  = (cnt == CNT_W'(DATA_WIDTH - 1));

  assign cur_dst  = dest_sel ? reg_b : reg_a;
  assign cur_src  = src_sel ? reg_b : reg_a;
  assign rd_reg   = signed'(cur_dst);
  assign rem_sh   = {acc[W-1:0], opy[W-1]};

  // immediate fitted to register width: truncate or sign-extend
  logic signed [63:0] imm64;
  assign imm64 = 64'(immediate);
  assign imm_w = imm64[W-1:0];

  // read value sign-extended to 64 bits, low 32 bits emitted
  logic signed [63:0] rd64;
  assign rd64 = 64'(rd_reg);

  // adder operand selection
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_IDLE: begin
        add_a = {1'b0, cur_dst};
        if (op_t'(req_type) == OP_SUB) begin
          add_b   = {1'b0, ~cur_src};
          add_cin = 1'b1;
        end else begin
          add_b = {1'b0, cur_src};
        end
      end
      S_MUL: begin
        add_a = acc;
        add_b = {1'b0, (opy[0] ? opx : {W{1'b0}})};
      end
      S_DIV_ABS_N: begin
        add_b   = {1'b0, ~opy};
        add_cin = 1'b1;
      end
      S_DIV_ABS_D: begin
        add_b   = {1'b0, ~opx};
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = rem_sh;
        add_b   = ~{1'b0, opx};
        add_cin = 1'b1;
      end
      S_DIV_FIX: begin
        add_b   = {1'b0, ~opy};
        add_cin = 1'b1;
      end
      S_WAIT_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, next state and outputs
  always_comb begin
    state_next       = state;
    acc_next         = acc;
    opx_next         = opx;
    opy_next         = opy;
    cnt_next         = cnt;
    dst_b_next       = dst_b;
    neg_n_next       = neg_n;
    neg_d_next       = neg_d;
    pend_kind_next   = pend_kind;
    pend_value_next  = pend_value;
    out_valid_next   = out_valid && !out_ready;
    result_kind_next = result_kind;
    read_value_next  = read_value;
    wr_en            = 1'b0;
    wr_sel           = dst_b;
    wr_val           = add_sum[W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          wr_sel     = dest_sel;
          dst_b_next = dest_sel;
          unique case (req_type)
            OP_LOAD: begin
              wr_en  = 1'b1;
              wr_val = imm_w;
            end
            OP_READ: begin
              pend_kind_next  = KIND_DATA;
              pend_value_next = rd64[31:0];
              if (slot_free) begin
                out_valid_next   = 1'b1;
                result_kind_next = KIND_DATA;
                read_value_next  = rd64[31:0];
              end else begin
                state_next = S_WAIT_OUT;
              end
            end
            OP_ADD, OP_SUB: begin
              wr_en = 1'b1;
            end
            OP_MUL: begin
              acc_next   = '0;
              opx_next   = cur_dst;
              opy_next   = cur_src;
              cnt_next   = '0;
              state_next = S_MUL;
            end
            OP_DIV: begin
              if (cur_src == '0) begin
                pend_kind_next  = KIND_DIV_ZERO;
                pend_value_next = '0;
                if (slot_free) begin
                  out_valid_next   = 1'b1;
                  result_kind_next = KIND_DIV_ZERO;
                  read_value_next  = '0;
                end else begin
                  state_next = S_WAIT_OUT;
                end
              end else begin
                acc_next   = '0;
                opy_next   = cur_dst;
                opx_next   = cur_src;
                neg_n_next = cur_dst[W-1];
                neg_d_next = cur_src[W-1];
                cnt_next   = '0;
                state_next = S_DIV_ABS_N;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one partial product per cycle, low bits only
      S_MUL: begin
        acc_next = {1'b0, add_sum[W-1:0]};
        opx_next = {opx[W-2:0], 1'b0};
        opy_next = {1'b0, opy[W-1:1]};
        cnt_next = cnt + CNT_W'(1);
        if (cnt_last) begin
          wr_en      = 1'b1;
          state_next = S_IDLE;
        end
      end

      // magnitudes of dividend and divisor
      S_DIV_ABS_N: begin
        if (neg_n) opy_next = add_sum[W-1:0];
        state_next = S_DIV_ABS_D;
      end
      S_DIV_ABS_D: begin
        if (neg_d) opx_next = add_sum[W-1:0];
        state_next = S_DIV;
      end

      // one restoring quotient bit per cycle
      S_DIV: begin
        if (add_sum[W]) begin
          acc_next = rem_sh;
          opy_next = {opy[W-2:0], 1'b0};
        end else begin
          acc_next = add_sum;
          opy_next = {opy[W-2:0], 1'b1};
        end
        cnt_next = cnt + CNT_W'(1);
        if (cnt_last) state_next = S_DIV_FIX;
      end

      // quotient sign and write-back
      S_DIV_FIX: begin
        wr_en      = 1'b1;
        wr_val     = (neg_n ^ neg_d) ? add_sum[W-1:0] : opy;
        state_next = S_IDLE;
      end

      // result held until the output register frees up
      S_WAIT_OUT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          result_kind_next = pend_kind;
          read_value_next  = pend_value;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // register write-back
  always_comb begin
    reg_a_next = reg_a;
    reg_b_next = reg_b;
    if (wr_en) begin
      if (wr_sel) reg_b_next = wr_val;
      else        reg_a_next = wr_val;
    end
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      reg_a     <= '0;
      reg_b     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      reg_a     <= reg_a_next;
      reg_b     <= reg_b_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk) begin
    acc         <= acc_next;
    opx         <= opx_next;
    opy         <= opy_next;
    cnt         <= cnt_next;
    dst_b       <= dst_b_next;
    neg_n       <= neg_n_next;
    neg_d       <= neg_d_next;
    pend_kind   <= pend_kind_next;
    pend_value  <= pend_value_next;
    result_kind <= result_kind_next;
    read_value  <= read_value_next;
  end

endmodule
